FILE: sv/neighbour_table_with_aging_core_macros.svh
// assertion macros shared by the rtl
`ifndef NEIGHBOUR_TABLE_WITH_AGING_CORE_MACROS_SVH
`define NEIGHBOUR_TABLE_WITH_AGING_CORE_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define NTA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define NTA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/nta_pkg.sv
`default_nettype none

package nta_pkg;

  localparam int ID_W      = 16;
  localparam int AGE_W     = 3;
  localparam int CNT_OUT_W = 5;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;

  localparam logic [AGE_W-1:0] AGE_MAX       = 3'd7;
  localparam logic [AGE_W-1:0] AGE_LIMIT_RST = 3'd4;

  // register index (byte address divided by four)
  localparam logic [PADDR_W-3:0] REG_AGE_LIMIT = 1'b0;

  typedef enum logic {
    OP_HEARD = 1'b0,
    OP_TICK  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DONE
  } state_t;

  // command broadcast to every cell while an item walks the chain
  typedef struct packed {
    op_t               op;
    logic [ID_W-1:0]   id;
    logic [AGE_W-1:0]  age_limit;
  } cmd_t;

  // flags handed from cell to cell
  typedef struct packed {
    logic active;
    logic found;
    logic free_seen;
  } flags_t;

endpackage

`default_nettype wire

FILE: sv/nta_cell.sv
`default_nettype none

module nta_cell #(
  parameter int IDX_W    = 4,
  parameter int CNT_W    = 5,
  parameter int CELL_IDX = 0
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire nta_pkg::cmd_t    cmd,
  input  wire logic             ins_en,
  input  wire logic [IDX_W-1:0] ins_idx,
  input  wire nta_pkg::flags_t  flags_in,
  input  wire logic [IDX_W-1:0] idx_in,
  input  wire logic [CNT_W-1:0] removed_in,
  output nta_pkg::flags_t       flags_out,
  output logic [IDX_W-1:0]      idx_out,
  output logic [CNT_W-1:0]      removed_out
);
  import nta_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic             valid;
  logic [ID_W-1:0]  id;
  logic [AGE_W-1:0] age;

  logic             hit;
  logic             expire;
  logic             heard;
  logic             tick;
  logic             ins_here;
  logic [AGE_W-1:0] age_inc;
  flags_t           flags_next;
  logic [IDX_W-1:0] idx_next;
  logic [CNT_W-1:0] removed_next;

  always_comb begin
    heard    = flags_in.active && (cmd.op == OP_HEARD);
    tick     = flags_in.active && (cmd.op == OP_TICK);
    ins_here = ins_en && (ins_idx == MY_IDX);
    hit      = valid && (id == cmd.id);
    // age saturates at its maximum
    age_inc  = (age == AGE_MAX) ? age : age + AGE_W'(1);
    expire   = valid && (age_inc >= cmd.age_limit);

    flags_next.active    = flags_in.active;
    flags_next.found     = flags_in.found | (heard & hit);
    flags_next.free_seen = flags_in.free_seen | (heard & ~valid);
    // keep the lowest free cell seen so far
    idx_next     = flags_in.free_seen ? idx_in : MY_IDX;
    removed_next = removed_in + CNT_W'(tick & expire);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ins_here) begin
      valid <= 1'b1;
    end else if (tick && expire) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ins_here) begin
      id  <= cmd.id;
      age <= '0;
    end else if (heard && hit) begin
      age <= '0;
    end else if (tick && valid) begin
      age <= age_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flags_out.active <= 1'b0;
    end else begin
      flags_out.active <= flags_next.active;
    end
    flags_out.found     <= flags_next.found;
    flags_out.free_seen <= flags_next.free_seen;
    idx_out             <= idx_next;
    removed_out         <= removed_next;
  end

endmodule

`default_nettype wire

FILE: sv/neighbour_table_with_aging_core.sv
// neighbour table with aging
// input channel (in_valid/in_ready) carries func and node_id: func 0 means a
// neighbour was heard, func 1 is an aging tick. output channel
// (out_valid/out_ready) returns one result per item: live entry count,
// added_new/refreshed/dropped_full for heard items, removed_count for ticks.
// each entry lives in one cell of a chain; an item is walked down the chain
// one cell per cycle, each cell comparing, aging or expiring its own entry and
// passing found/free/removed info to the next cell. a new id is written into
// the lowest free cell once the walk has finished.
// one item is in flight at a time: the result is registered once the item has
// walked the whole cell chain, and the next item is taken only after that result
// is loaded into the output register.
// when the receiver stalls the finished result is held in the output register;
// the next item is still taken and walked, then waits until that result leaves.
// the user must write age_limit over the apb port only while the block is idle;
// the block does not enforce this. reset (synchronous, active high) empties the
// table, clears the count and sets age_limit to 4; no clearing pass is needed.
`default_nettype none

`include "neighbour_table_with_aging_core_macros.svh"

module neighbour_table_with_aging_core #(
  parameter int DEPTH = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic                             func,
  input  wire logic [nta_pkg::ID_W-1:0]         node_id,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [nta_pkg::CNT_OUT_W-1:0]         neighbour_count,
  output logic                                  added_new,
  output logic                                  refreshed,
  output logic                                  dropped_full,
  output logic [nta_pkg::CNT_OUT_W-1:0]         removed_count,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [nta_pkg::PADDR_W-1:0]      paddr,
  input  wire logic [nta_pkg::PDATA_W-1:0]      pwdata,
  output logic [nta_pkg::PDATA_W-1:0]           prdata,
  output logic                                  pready
);
  import nta_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  state_t            state;
  state_t            state_next;
  cmd_t              cmd;
  logic              start;
  logic [AGE_W-1:0]  age_limit;
  logic [CNT_W-1:0]  live_cnt;
  logic [CNT_W-1:0]  live_next;

  logic              res_found;
  logic              res_free;
  logic [IDX_W-1:0]  res_idx;
  logic [CNT_W-1:0]  res_removed;

  logic              accept;
  logic              load_out;
  logic              ins_en;
  logic              cfg_wr;
  logic              reg_hit;

  flags_t            chain_flags [DEPTH+1];
  logic [IDX_W-1:0]  chain_idx   [DEPTH+1];
  logic [CNT_W-1:0]  chain_rem   [DEPTH+1];

  // configuration port
  assign pready  = 1'b1;
  assign reg_hit = (paddr[PADDR_W-1:2] == REG_AGE_LIMIT);
  assign cfg_wr  = psel && penable && pwrite && pready && reg_hit;
  assign prdata  = reg_hit ? PDATA_W'(age_limit) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      age_limit <= AGE_LIMIT_RST;
    end else if (cfg_wr) begin
      age_limit <= pwdata[AGE_W-1:0];
    end
  end

  // cell chain
  assign chain_flags[0] = '{active: start, found: 1'b0, free_seen: 1'b0};
  assign chain_idx[0]   = '0;
  assign chain_rem[0]   = '0;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    nta_cell #(
      .IDX_W    (IDX_W),
      .CNT_W    (CNT_W),
      .CELL_IDX (g)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .cmd         (cmd),
      .ins_en      (ins_en),
      .ins_idx     (res_idx),
      .flags_in    (chain_flags[g]),
      .idx_in      (chain_idx[g]),
      .removed_in  (chain_rem[g]),
      .flags_out   (chain_flags[g+1]),
      .idx_out     (chain_idx[g+1]),
      .removed_out (chain_rem[g+1])
    );
  end

  // control
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    load_out   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_next = S_RUN;
      end
      S_RUN: begin
        if (chain_flags[DEPTH].active) state_next = S_DONE;
      end
      S_DONE: begin
        // wait here while the previous result is still stalled
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign accept = in_valid && in_ready;
  assign ins_en = load_out && (cmd.op == OP_HEARD) && !res_found && res_free;

  always_comb begin
    if (cmd.op == OP_HEARD) begin
      live_next = live_cnt + CNT_W'(ins_en);
    end else begin
      live_next = (live_cnt >= res_removed) ? live_cnt - res_removed : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      start    <= 1'b0;
      live_cnt <= '0;
    end else begin
      state <= state_next;
      start <= accept;
      if (load_out) live_cnt <= live_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd.op        <= op_t'(func);
      cmd.id        <= node_id;
    end
    cmd.age_limit <= age_limit;
    if (chain_flags[DEPTH].active) begin
      res_found   <= chain_flags[DEPTH].found;
      res_free    <= chain_flags[DEPTH].free_seen;
      res_idx     <= chain_idx[DEPTH];
      res_removed <= chain_rem[DEPTH];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      neighbour_count <= CNT_OUT_W'(live_next);
      if (cmd.op == OP_HEARD) begin
        added_new     <= ins_en;
        refreshed     <= res_found;
        dropped_full  <= !res_found && !res_free;
        removed_count <= '0;
      end else begin
        added_new     <= 1'b0;
        refreshed     <= 1'b0;
        dropped_full  <= 1'b0;
        removed_count <= CNT_OUT_W'(res_removed);
      end
    end
  end

  `NTA_ASSERT_IMP(a_live_bound, 1'b1, live_cnt <= CNT_W'(DEPTH), "live count above depth")
  `NTA_ASSERT_IMP(a_ins_room, ins_en, live_cnt < CNT_W'(DEPTH), "insert into a full table")
  `NTA_ASSERT_IMP(a_tok_state, chain_flags[DEPTH].active, state == S_RUN,
    "chain finished outside a walk")
  `NTA_ASSERT_NEXT(a_one_flag, load_out, $onehot0({added_new, refreshed, dropped_full}),
    "more than one heard flag set")

endmodule

`default_nettype wire
